// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the command parser.
// Depends on nothing; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AP_IMPLY(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define AP_NEXT(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

// ----- rtl/aclp_pkg.sv -----
// Package of the command parser: byte codes, the command table, lamp masks,
// the control state type and the matcher control struct. Depends on nothing.
package aclp_pkg;

	// Default text buffer depth in bytes.
	localparam int DEFAULT_BUFFER_DEPTH = 32;

	localparam int BYTE_W    = 8;
	localparam int CODE_W    = 4;
	localparam int LAMP_W    = 3;
	localparam int POS_W     = 3;
	localparam int NUM_CMDS  = 10;
	localparam int CMD_IDX_W = 4;

	localparam logic [BYTE_W-1:0] BYTE_START = 8'h41;
	localparam logic [BYTE_W-1:0] BYTE_END   = 8'h2A;
	localparam logic [BYTE_W-1:0] BYTE_NUL   = 8'h00;

	localparam logic [CODE_W-1:0] CODE_NONE = 4'd0;

	localparam logic [LAMP_W-1:0] LAMP_OFF   = 3'b000;
	localparam logic [LAMP_W-1:0] LAMP_RED   = 3'b001;
	localparam logic [LAMP_W-1:0] LAMP_BLUE  = 3'b010;
	localparam logic [LAMP_W-1:0] LAMP_GREEN = 3'b100;

	// Saturated position: positions at or beyond this value all read as it.
	localparam logic [POS_W-1:0] POS_SAT = 3'd7;

	// Command texts, first character in the top byte, short ones padded with NUL.
	localparam logic [6*BYTE_W-1:0] CMD_TEXT [NUM_CMDS] = '{
		"AT+R=1", "AT+R=0", "AT+G=1", "AT+G=0", "AT+P=1",
		"AT+P=0", "AT+Y=1", "AT+Y=0", {"AT+ON", 8'h00}, "AT+OFF"
	};

	localparam logic [POS_W-1:0] CMD_LEN [NUM_CMDS] = '{
		3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd5, 3'd6
	};

	localparam logic [LAMP_W-1:0] CMD_SET [NUM_CMDS] = '{
		LAMP_RED, LAMP_OFF, LAMP_GREEN, LAMP_OFF, LAMP_RED | LAMP_BLUE,
		LAMP_OFF, LAMP_RED | LAMP_GREEN, LAMP_OFF,
		LAMP_RED | LAMP_GREEN | LAMP_BLUE, LAMP_OFF
	};

	localparam logic [LAMP_W-1:0] CMD_CLR [NUM_CMDS] = '{
		LAMP_OFF, LAMP_RED, LAMP_OFF, LAMP_GREEN, LAMP_OFF,
		LAMP_RED | LAMP_BLUE, LAMP_OFF, LAMP_RED | LAMP_GREEN,
		LAMP_OFF, LAMP_RED | LAMP_GREEN | LAMP_BLUE
	};

	// Control states of the parser.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_COLLECT,
		ST_SCAN,
		ST_RESULT
	} aclp_state_t;

	// Control from the sequencer to the matcher.
	typedef struct packed {
		logic             clear;
		logic             step;
		logic [POS_W-1:0] pos;
	} match_ctrl_t;

	// Character of a command at a position; only valid below the command length.
	function automatic logic [BYTE_W-1:0] cmd_char(input logic [CMD_IDX_W-1:0] k,
			input logic [POS_W-1:0] p);
		logic [6*BYTE_W-1:0] t;
		t = CMD_TEXT[k] << {p, 3'b000};
		return t[6*BYTE_W-1 -: BYTE_W];
	endfunction

	// Lamp bits after a command; an unrecognized code leaves them as they are.
	function automatic logic [LAMP_W-1:0] lamp_update(input logic [LAMP_W-1:0] lamps,
			input logic [CODE_W-1:0] code);
		logic [CMD_IDX_W-1:0] idx;
		idx = CMD_IDX_W'(code - 4'd1);
		if (code == CODE_NONE) begin
			return lamps;
		end
		return (lamps | CMD_SET[idx]) & ~CMD_CLR[idx];
	endfunction

endpackage

// ----- rtl/aclp_matcher.sv -----
// Command matcher: tracks which of the fixed commands still agree with the
// characters seen so far and yields the code of the match. Depends on aclp_pkg.
module aclp_matcher
	import aclp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  match_ctrl_t       ctrl,
	input  logic [BYTE_W-1:0] rd_byte,
	output logic [CODE_W-1:0] code
);

	logic [NUM_CMDS-1:0] alive_q;
	logic [NUM_CMDS-1:0] alive_d;
	logic [POS_W-1:0]    len_q;

	// A command drops out on a differing character or once the text outruns it.
	always_comb begin
		alive_d = alive_q;
		for (int k = 0; k < NUM_CMDS; k++) begin
			if (ctrl.pos >= CMD_LEN[k] ||
					rd_byte != cmd_char(CMD_IDX_W'(k), ctrl.pos)) begin
				alive_d[k] = 1'b0;
			end
		end
	end

	// Candidate flags and the saturated text length.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alive_q <= '1;
			len_q   <= '0;
		end else if (ctrl.clear) begin
			alive_q <= '1;
			len_q   <= '0;
		end else if (ctrl.step) begin
			alive_q <= alive_d;
			len_q   <= (ctrl.pos == POS_SAT) ? POS_SAT : ctrl.pos + 3'd1;
		end
	end

	// The lowest-numbered command of exactly the text length wins.
	always_comb begin
		code = CODE_NONE;
		for (int k = NUM_CMDS - 1; k >= 0; k--) begin
			if (alive_q[k] && len_q == CMD_LEN[k]) begin
				code = CODE_W'(k + 1);
			end
		end
	end

endmodule

// ----- rtl/at_command_led_parser_unit.sv -----
// Command parser top level: byte buffer memory, scan sequencer and lamp state.
// Depends on aclp_pkg, aclp_matcher and assert_macros.svh.
//
// Usage. Each input request carries one received byte on rx_byte. While idle,
// only 'A' is taken as a command start; other bytes are accepted and dropped.
// Bytes up to '*' are written to the buffer memory, one per request; once
// BUFFER_DEPTH-1 bytes are held, further bytes are dropped. A '*' ends the
// command and gives exactly one output request with command_code (0 when
// unrecognized) and lamp_state after the command. Before it, the scan reads
// the stored bytes up to the first zero byte (at most BUFFER_DEPTH-1) from
// the buffer memory, one byte per cycle through its single registered read
// port. in_stall is high during the scan and result cycles, so one command is
// parsed at a time; between commands, bytes are taken one per cycle. The
// result sits in an output register; if out_stall holds it, the next command
// still collects and waits only at its own result cycle. Reset clears the
// control state, the lamps and the output valid; the buffer memory is not
// cleared, since only bytes written by the current command are ever read.
module at_command_led_parser_unit
	import aclp_pkg::*;
#(
	parameter int BUFFER_DEPTH = DEFAULT_BUFFER_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [BYTE_W-1:0] rx_byte,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [CODE_W-1:0] command_code,
	output logic [LAMP_W-1:0] lamp_state
);

	`include "assert_macros.svh"

	localparam int PTR_W = $clog2(BUFFER_DEPTH);
	localparam logic [PTR_W-1:0] FILL_MAX = PTR_W'(BUFFER_DEPTH - 1);

	aclp_state_t state_q, state_d;

	logic [BYTE_W-1:0] mem_q [BUFFER_DEPTH];
	logic [PTR_W-1:0]  fill_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [BYTE_W-1:0] rd_data_s1;
	logic              rd_vld_s1;
	logic [POS_W-1:0]  pos_s1;
	logic [LAMP_W-1:0] lamps_q;
	logic              out_valid_q;
	logic [CODE_W-1:0] command_code_q;
	logic [LAMP_W-1:0] lamp_state_q;

	logic              in_acc;
	logic              is_start;
	logic              is_end;
	logic              wr_en;
	logic [PTR_W-1:0]  wr_addr;
	logic              issue;
	logic              stop;
	logic              load;
	logic [POS_W-1:0]  pos_sat;
	logic [CODE_W-1:0] match_code;
	logic [LAMP_W-1:0] lamps_next;
	logic              res_held;
	match_ctrl_t       mctrl;

	assign in_acc   = in_valid && !in_stall;
	assign is_start = (rx_byte == BYTE_START);
	assign is_end   = (rx_byte == BYTE_END);
	assign stop     = rd_vld_s1 && (rd_data_s1 == BYTE_NUL);
	assign pos_sat  = (rd_ptr_q > PTR_W'(POS_SAT)) ? POS_SAT : rd_ptr_q[POS_W-1:0];

	// Next state of the sequencer.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && is_start) begin
					state_d = ST_COLLECT;
				end
			end
			ST_COLLECT: begin
				if (in_acc && is_end) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (stop || (!issue && !rd_vld_s1)) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs. Writes happen only while idle or collecting and reads
	// only while scanning, so the memory never sees both on one entry at once.
	// The input is never stalled while idle or collecting, so a valid byte
	// there is always accepted.
	always_comb begin
		in_stall    = 1'b0;
		wr_en       = 1'b0;
		wr_addr     = fill_q;
		issue       = 1'b0;
		load        = 1'b0;
		mctrl.clear = 1'b0;
		mctrl.step  = 1'b0;
		mctrl.pos   = pos_s1;
		unique case (state_q)
			ST_IDLE: begin
				wr_en   = in_valid && is_start;
				wr_addr = '0;
			end
			ST_COLLECT: begin
				wr_en       = in_valid && !is_end && (fill_q != FILL_MAX);
				mctrl.clear = in_valid && is_end;
			end
			ST_SCAN: begin
				in_stall   = 1'b1;
				issue      = (rd_ptr_q != fill_q);
				mctrl.step = rd_vld_s1 && !stop;
			end
			ST_RESULT: begin
				in_stall = 1'b1;
				load     = !out_valid_q || !out_stall;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	// Buffer memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= rx_byte;
		end
		if (issue) begin
			rd_data_s1 <= mem_q[rd_ptr_q];
		end
	end

	// Position of the byte in the read stage, saturated for the matcher.
	always_ff @(posedge clk) begin
		if (issue) begin
			pos_s1 <= pos_sat;
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			fill_q    <= '0;
			rd_ptr_q  <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= issue && !stop;
			if (wr_en) begin
				fill_q <= wr_addr + PTR_W'(1);
			end
			if (mctrl.clear) begin
				rd_ptr_q <= '0;
			end else if (issue) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
		end
	end

	aclp_matcher u_matcher (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (mctrl),
		.rd_byte (rd_data_s1),
		.code    (match_code)
	);

	assign lamps_next = lamp_update(lamps_q, match_code);

	// Lamp state and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lamps_q     <= LAMP_OFF;
			out_valid_q <= 1'b0;
		end else if (load) begin
			lamps_q     <= lamps_next;
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			command_code_q <= match_code;
			lamp_state_q   <= lamps_next;
		end
	end

	assign out_valid    = out_valid_q;
	assign command_code = command_code_q;
	assign lamp_state   = lamp_state_q;

	// A result is waiting in the output register at the result cycle.
	assign res_held = (state_q == ST_RESULT) && out_valid_q;

	// A terminator while collecting always starts the scan.
	`AP_NEXT(a_end_starts_scan, clk, arst_n, in_acc && state_q == ST_COLLECT && is_end, state_q == ST_SCAN)
	// Read data is only in flight during the scan.
	`AP_IMPLY(a_read_in_scan, clk, arst_n, rd_vld_s1, state_q == ST_SCAN)
	// A held result is never overwritten by the next command.
	`AP_NEXT(a_result_waits, clk, arst_n, res_held && out_stall, res_held)
	// An unrecognized command leaves the lamps as they were.
	`AP_NEXT(a_none_keeps_lamps, clk, arst_n, load && match_code == CODE_NONE, lamp_state == $past(lamps_q))

endmodule

// ----- tb/tb_at_command_led_parser_unit.sv -----
`timescale 1ns / 100ps
// Testbench for the command parser: drives received bytes, predicts each command result
// and checks every output request. Depends on aclp_pkg and at_command_led_parser_unit.
module tb_at_command_led_parser_unit;
	import aclp_pkg::*;

	localparam int TEXT_DEPTH  = DEFAULT_BUFFER_DEPTH;
	localparam int HOLD_CYCLES = 400;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_ITEMS = 450;

	localparam logic [LAMP_W-1:0] RED_BIT   = 3'b001;
	localparam logic [LAMP_W-1:0] BLUE_BIT  = 3'b010;
	localparam logic [LAMP_W-1:0] GREEN_BIT = 3'b100;

	typedef enum logic [CODE_W-1:0] {
		CMD_NONE,
		CMD_RED_ON,
		CMD_RED_OFF,
		CMD_GREEN_ON,
		CMD_GREEN_OFF,
		CMD_PURPLE_ON,
		CMD_PURPLE_OFF,
		CMD_YELLOW_ON,
		CMD_YELLOW_OFF,
		CMD_ALL_ON,
		CMD_ALL_OFF
	} led_cmd_t;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [LAMP_W-1:0] lamps;
	} lamp_result_t;

	// Tracks the parser state from accepted requests and holds the expected results.
	class lamp_scoreboard;
		bit                collecting;
		int                fill;
		logic [BYTE_W-1:0] text_buf [TEXT_DEPTH];
		logic [LAMP_W-1:0] lamps;
		lamp_result_t      expected_q [$];
		int                errors;

		function new();
			collecting = 1'b0;
			fill       = 0;
			lamps      = '0;
			errors     = 0;
		endfunction

		function string text_of(led_cmd_t c);
			case (c)
				CMD_RED_ON:     return "AT+R=1";
				CMD_RED_OFF:    return "AT+R=0";
				CMD_GREEN_ON:   return "AT+G=1";
				CMD_GREEN_OFF:  return "AT+G=0";
				CMD_PURPLE_ON:  return "AT+P=1";
				CMD_PURPLE_OFF: return "AT+P=0";
				CMD_YELLOW_ON:  return "AT+Y=1";
				CMD_YELLOW_OFF: return "AT+Y=0";
				CMD_ALL_ON:     return "AT+ON";
				CMD_ALL_OFF:    return "AT+OFF";
				default:        return "";
			endcase
		endfunction

		function logic [LAMP_W-1:0] set_of(led_cmd_t c);
			case (c)
				CMD_RED_ON:    return RED_BIT;
				CMD_GREEN_ON:  return GREEN_BIT;
				CMD_PURPLE_ON: return RED_BIT | BLUE_BIT;
				CMD_YELLOW_ON: return RED_BIT | GREEN_BIT;
				CMD_ALL_ON:    return RED_BIT | GREEN_BIT | BLUE_BIT;
				default:       return '0;
			endcase
		endfunction

		function logic [LAMP_W-1:0] clear_of(led_cmd_t c);
			case (c)
				CMD_RED_OFF:    return RED_BIT;
				CMD_GREEN_OFF:  return GREEN_BIT;
				CMD_PURPLE_OFF: return RED_BIT | BLUE_BIT;
				CMD_YELLOW_OFF: return RED_BIT | GREEN_BIT;
				CMD_ALL_OFF:    return RED_BIT | GREEN_BIT | BLUE_BIT;
				default:        return '0;
			endcase
		endfunction

		// The stored text counts only up to its first zero byte.
		function led_cmd_t decode();
			int    len;
			string t;
			bit    same;
			len = 0;
			while (len < fill && text_buf[len] != BYTE_NUL) len++;
			for (int k = 1; k <= 10; k++) begin
				t = text_of(led_cmd_t'(k));
				if (t.len() == len) begin
					same = 1'b1;
					for (int i = 0; i < len; i++) begin
						if (text_buf[i] != t[i]) same = 1'b0;
					end
					if (same) return led_cmd_t'(k);
				end
			end
			return CMD_NONE;
		endfunction

		function void note_request(logic [BYTE_W-1:0] b);
			led_cmd_t     c;
			lamp_result_t r;
			if (!collecting) begin
				if (b == BYTE_START) begin
					collecting  = 1'b1;
					text_buf[0] = b;
					fill        = 1;
				end
			end else if (b == BYTE_END) begin
				c = decode();
				if (c != CMD_NONE) lamps = (lamps | set_of(c)) & ~clear_of(c);
				collecting = 1'b0;
				fill       = 0;
				r.code     = c;
				r.lamps    = lamps;
				expected_q.push_back(r);
			end else if (fill < TEXT_DEPTH - 1) begin
				text_buf[fill] = b;
				fill++;
			end
		endfunction

		function void check_result(logic [CODE_W-1:0] code, logic [LAMP_W-1:0] lamps_seen);
			lamp_result_t r;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result code %0d lamps %0d", $time, code, lamps_seen);
				errors++;
				return;
			end
			r = expected_q.pop_front();
			if (code !== r.code) begin
				$display("%0t: command_code expected %0d actual %0d", $time, r.code, code);
				errors++;
			end
			if (lamps_seen !== r.lamps) begin
				$display("%0t: lamp_state expected %0d actual %0d", $time, r.lamps, lamps_seen);
				errors++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic              in_stall;
	logic [BYTE_W-1:0] rx_byte   = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [CODE_W-1:0] command_code;
	logic [LAMP_W-1:0] lamp_state;

	lamp_scoreboard    sb;
	logic [BYTE_W-1:0] cmd_bytes [$];
	int                items_sent    = 0;
	int                send_idle_pct = 0;
	int                recv_idle_pct = 0;
	int                hold_trigger  = 0;
	int                hold_served   = 0;
	int                hold_left     = 0;
	int                cycle_count   = 0;

	at_command_led_parser_unit DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.command_code(command_code),
		.lamp_state  (lamp_state)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Receiver stall: random, or a long hold-off when the stimulus asks for one.
	always @(posedge clk) begin
		if (hold_trigger != hold_served) begin
			hold_served <= hold_trigger;
			hold_left   <= HOLD_CYCLES;
			out_stall   <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Every accepted output request is checked against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check_result(command_code, lamp_state);
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Offers one byte, with random idle cycles ahead of it, and waits until it is taken.
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_request(b);
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++) cmd_bytes.push_back(s[i]);
	endtask

	// Sends the collected bytes; idle noise does not count toward the item total.
	task automatic flush_bytes(input bit counted);
		foreach (cmd_bytes[i]) begin
			send_byte(cmd_bytes[i]);
			if (counted) items_sent++;
		end
		cmd_bytes.delete();
	endtask

	function automatic logic [BYTE_W-1:0] rand_text_byte();
		logic [BYTE_W-1:0] b;
		do b = BYTE_W'($urandom_range(255)); while (b == BYTE_END);
		return b;
	endfunction

	// One random command: mostly well formed, the rest broken, long or plain noise.
	task automatic random_command();
		led_cmd_t c;
		string    t;
		int       kind;
		int       n;
		c    = led_cmd_t'($urandom_range(1, 10));
		t    = sb.text_of(c);
		kind = $urandom_range(99);
		if (kind < 60) begin
			add_text(t);
		end else if (kind < 70) begin
			add_text(t);
			cmd_bytes[$urandom_range(1, t.len() - 1)] = rand_text_byte();
		end else if (kind < 78) begin
			if ($urandom_range(1)) begin
				add_text(t.substr(0, $urandom_range(0, t.len() - 2)));
			end else begin
				add_text(t);
				n = $urandom_range(1, 3);
				repeat (n) cmd_bytes.push_back(rand_text_byte());
			end
		end else if (kind < 86) begin
			add_text(t);
			cmd_bytes.push_back(BYTE_NUL);
			n = $urandom_range(0, 4);
			repeat (n) cmd_bytes.push_back(BYTE_W'($urandom_range(255)));
		end else if (kind < 90) begin
			// Long text, which can run past the end of the buffer.
			if ($urandom_range(1)) begin
				add_text(t);
				cmd_bytes.push_back(BYTE_NUL);
			end else begin
				cmd_bytes.push_back(BYTE_START);
			end
			n = $urandom_range(26, 40);
			repeat (n) cmd_bytes.push_back(rand_text_byte());
		end else begin
			n = $urandom_range(1, 4);
			repeat (n) cmd_bytes.push_back(BYTE_W'($urandom_range(255)));
			flush_bytes(1'b0);
			return;
		end
		cmd_bytes.push_back(BYTE_END);
		flush_bytes(1'b1);
	endtask

	initial begin
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Bytes while idle, including a lone terminator, are ignored.
		cmd_bytes = '{8'h00, 8'hFF, BYTE_END};
		flush_bytes(1'b0);
		add_text("AT+ON*");
		add_text("AT+P=0*");
		// A second start byte inside a command is plain text.
		add_text("AA*");
		// Text after a zero byte is not compared.
		add_text("AT+Y=1");
		cmd_bytes.push_back(BYTE_NUL);
		add_text("Q*");
		flush_bytes(1'b1);

		// Sender idles rarely, receiver often; one long hold-off fills the block.
		send_idle_pct = 13;
		recv_idle_pct <= 58;
		hold_trigger  <= hold_trigger + 1;
		while (items_sent < PHASE_ITEMS) random_command();

		send_idle_pct = 58;
		recv_idle_pct <= 13;
		while (items_sent < 2 * PHASE_ITEMS) random_command();

		// No idling on either side, with one more hold-off.
		send_idle_pct = 0;
		recv_idle_pct <= 0;
		hold_trigger  <= hold_trigger + 1;
		while (items_sent < 3 * PHASE_ITEMS) random_command();

		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (TEXT_DEPTH + 8) @(posedge clk);
		if (sb.errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
